### rtl/load_store_align_unit_assert.svh
// Assertion macros shared by the load/store align unit modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LOAD_STORE_ALIGN_UNIT_ASSERT_SVH
`define LOAD_STORE_ALIGN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lsau_pkg.sv
// Shared types and constants of the load/store align unit.
// No dependencies; the front, back and top-level files refer to it by scoped names.
package lsau_pkg;

  localparam int MEM_BYTES_DEFAULT = 65536;
  localparam int QUEUE_DEPTH       = 2;
  localparam int WORD_BYTES        = 4;

  typedef enum logic [3:0] {
    OP_FETCH = 4'd0,
    OP_LDW   = 4'd1,
    OP_LDH   = 4'd2,
    OP_LDB   = 4'd3,
    OP_LDD   = 4'd4,
    OP_LD4   = 4'd5,
    OP_LD2   = 4'd6,
    OP_STB   = 4'd7,
    OP_STH   = 4'd8,
    OP_STW   = 4'd9,
    OP_STD   = 4'd10
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ALIGN  = 2'd1;
  localparam logic [1:0] ST_WINDOW = 2'd2;

  // One classified access as it travels from the front to the back.
  typedef struct packed {
    logic        load;
    logic        write;
    logic [1:0]  status;
    logic [1:0]  nbeats;
    logic [2:0]  nbytes;
    logic [1:0]  rot;
    logic        swap;
    logic [63:0] wdata;
  } cmd_t;

  // Flow control seen by the front.
  typedef struct packed {
    logic queue_full;
    logic clearing;
  } front_ctl_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_BEAT1,
    BK_FIN
  } back_state_t;

endpackage

### rtl/lsau_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lsau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/lsau_cmd_queue.sv
// Short in-order queue of classified accesses between front and back.
// Depends on the assertion header.
`include "load_store_align_unit_assert.svh"

module lsau_cmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign valid = (count != '0);
  assign full  = (count == (PW+1)'(DEPTH));
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  `LSAU_ASSERT_IMPL(a_no_overflow, push, !full, "command pushed into a full queue")
  `LSAU_ASSERT_IMPL(a_no_underflow, pop, count != '0, "command popped from an empty queue")

endmodule

### rtl/lsau_front.sv
// Front end: holds the window base, accepts commands and classifies them
// into faults and memory beats. Depends on lsau_pkg.
module lsau_front #(
  parameter int MEM_BYTES = lsau_pkg::MEM_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    operation,
  input  logic [31:0]                   address,
  input  logic [63:0]                   write_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data,
  input  lsau_pkg::front_ctl_t          ctl,
  output logic                          push,
  output lsau_pkg::cmd_t                cmd,
  output logic [$clog2(MEM_BYTES)-1:0]  off0,
  output logic [$clog2(MEM_BYTES)-1:0]  off1
);

  localparam int          OW        = $clog2(MEM_BYTES);
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  logic [31:0]     window_base;
  logic [31:0]     g_al4;
  logic [31:0]     g_al2;
  logic [31:0]     g_hi;
  logic [31:0]     g0;
  logic [31:0]     o0;
  logic [31:0]     o1;
  lsau_pkg::op_t   op;

  // True when n bytes starting at store offset o all lie in the window.
  function automatic logic fits(input logic [31:0] o, input logic [2:0] n);
    return ({1'b0, o} + {30'd0, n}) <= MEM_LIMIT;
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = ctl.queue_full || ctl.clearing;
  assign push      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      window_base <= cfg_data;
    end
  end

  assign op    = lsau_pkg::op_t'(operation);
  assign g_al4 = {address[31:2], 2'b00};
  assign g_al2 = {address[31:1], 1'b0};
  assign g_hi  = g_al4 + 32'd4;

  always_comb begin
    case (op)
      lsau_pkg::OP_LDW, lsau_pkg::OP_LDD: g0 = g_al4;
      lsau_pkg::OP_LDH:                   g0 = g_al2;
      default:                            g0 = address;
    endcase
  end

  assign o0   = g0 - window_base;
  assign o1   = g_hi - window_base;
  assign off0 = o0[OW-1:0];
  assign off1 = o1[OW-1:0];

  always_comb begin
    cmd       = '0;
    cmd.wdata = write_data;
    case (op)
      lsau_pkg::OP_FETCH: begin
        if (address[1:0] != 2'b00) begin
          cmd.status = lsau_pkg::ST_ALIGN;
        end else if (!fits(o0, 3'd4)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd4;
        end
      end
      lsau_pkg::OP_LDW: begin
        if (!fits(o0, 3'd4)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd4;
          cmd.rot    = address[1:0];
        end
      end
      lsau_pkg::OP_LDH: begin
        if (!fits(o0, 3'd2)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd2;
          cmd.swap   = address[0];
        end
      end
      lsau_pkg::OP_LDB: begin
        if (!fits(o0, 3'd1)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd1;
        end
      end
      lsau_pkg::OP_LDD: begin
        if (!fits(o0, 3'd4) || !fits(o1, 3'd4)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd2;
          cmd.nbytes = 3'd4;
          cmd.rot    = address[1:0];
        end
      end
      lsau_pkg::OP_LD4, lsau_pkg::OP_LD2: begin
        cmd.nbytes = (op == lsau_pkg::OP_LD4) ? 3'd4 : 3'd2;
        if (!fits(o0, cmd.nbytes)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.load   = 1'b1;
          cmd.nbeats = 2'd1;
        end
      end
      lsau_pkg::OP_STB: begin
        if (!fits(o0, 3'd1)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.write  = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd1;
        end
      end
      lsau_pkg::OP_STH: begin
        if (address[0]) begin
          cmd.status = lsau_pkg::ST_ALIGN;
        end else if (!fits(o0, 3'd2)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.write  = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd2;
        end
      end
      lsau_pkg::OP_STW: begin
        if (address[1:0] != 2'b00) begin
          cmd.status = lsau_pkg::ST_ALIGN;
        end else if (!fits(o0, 3'd4)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          cmd.write  = 1'b1;
          cmd.nbeats = 2'd1;
          cmd.nbytes = 3'd4;
        end
      end
      lsau_pkg::OP_STD: begin
        if (address[1:0] != 2'b00) begin
          cmd.status = lsau_pkg::ST_ALIGN;
        end else if (!fits(o0, 3'd4)) begin
          cmd.status = lsau_pkg::ST_WINDOW;
        end else begin
          // The low word is written even when the high word falls outside.
          cmd.write  = 1'b1;
          cmd.nbytes = 3'd4;
          if (fits(o1, 3'd4)) begin
            cmd.nbeats = 2'd2;
          end else begin
            cmd.nbeats = 2'd1;
            cmd.status = lsau_pkg::ST_WINDOW;
          end
        end
      end
      default: begin
        cmd.status = lsau_pkg::ST_OK;
      end
    endcase
  end

endmodule

### rtl/lsau_back.sv
// Back end: clears the byte store after reset, runs memory beats on four
// byte-lane RAMs and forms the result. Depends on lsau_pkg and lsau_ram.
`include "load_store_align_unit_assert.svh"

module lsau_back #(
  parameter int MEM_BYTES = lsau_pkg::MEM_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  lsau_pkg::cmd_t                q_cmd,
  input  logic [$clog2(MEM_BYTES)-1:0]  q_off0,
  input  logic [$clog2(MEM_BYTES)-1:0]  q_off1,
  output logic                          pop,
  output logic                          clearing,
  output logic                          done,
  output logic [63:0]                   read_data,
  output logic [1:0]                    status
);

  localparam int OW    = $clog2(MEM_BYTES);
  localparam int LANES = lsau_pkg::WORD_BYTES;
  localparam int WORDS = (MEM_BYTES + LANES - 1) / LANES;
  localparam int RW    = $clog2(WORDS);

  lsau_pkg::back_state_t state;
  lsau_pkg::back_state_t state_next;

  lsau_pkg::cmd_t  cur;
  logic [OW-1:0]   cur_off1;
  logic [1:0]      lane_q;
  logic [31:0]     lo_word;
  logic [RW-1:0]   clr_row;

  logic            issue_en;
  logic            issue_write;
  logic [OW-1:0]   issue_s;
  logic [31:0]     issue_wdata;
  logic [2:0]      issue_nbytes;
  logic            clear_en;

  logic [LANES-1:0] bank_we;
  logic [RW-1:0]    bank_addr  [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic [7:0]       bank_rdata [LANES];

  logic [31:0]     raw;
  logic [31:0]     shaped;

  // Keep the bytes of the access, rotate a word load, swap an odd halfword.
  function automatic logic [31:0] shape(input logic [31:0] bytes_in,
                                        input logic [2:0]  nbytes,
                                        input logic [1:0]  rot,
                                        input logic        swap);
    logic [31:0] v;
    logic [63:0] dbl;
    for (int i = 0; i < LANES; i++) begin
      v[8*i +: 8] = (3'(i) < nbytes) ? bytes_in[8*i +: 8] : 8'h00;
    end
    dbl = {v, v} >> {rot, 3'b000};
    v   = dbl[31:0];
    if (swap) begin
      v = {16'h0000, v[7:0], v[15:8]};
    end
    return v;
  endfunction

  assign clearing = (state == lsau_pkg::BK_CLEAR);

  always_comb begin
    case (state)
      lsau_pkg::BK_CLEAR: begin
        state_next = (clr_row == RW'(WORDS - 1)) ? lsau_pkg::BK_IDLE : lsau_pkg::BK_CLEAR;
      end
      lsau_pkg::BK_IDLE: begin
        if (!q_valid) begin
          state_next = lsau_pkg::BK_IDLE;
        end else if (q_cmd.nbeats == 2'd2) begin
          state_next = lsau_pkg::BK_BEAT1;
        end else begin
          state_next = lsau_pkg::BK_FIN;
        end
      end
      lsau_pkg::BK_BEAT1: state_next = lsau_pkg::BK_FIN;
      lsau_pkg::BK_FIN:   state_next = lsau_pkg::BK_IDLE;
      default:            state_next = lsau_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    clear_en     = 1'b0;
    issue_en     = 1'b0;
    issue_write  = 1'b0;
    issue_s      = q_off0;
    issue_wdata  = q_cmd.wdata[31:0];
    issue_nbytes = q_cmd.nbytes;
    case (state)
      lsau_pkg::BK_CLEAR: begin
        clear_en = 1'b1;
      end
      lsau_pkg::BK_IDLE: begin
        pop         = q_valid;
        issue_en    = q_valid && (q_cmd.nbeats != 2'd0);
        issue_write = q_cmd.write;
      end
      lsau_pkg::BK_BEAT1: begin
        issue_en     = 1'b1;
        issue_write  = cur.write;
        issue_s      = cur_off1;
        issue_wdata  = cur.wdata[63:32];
        issue_nbytes = cur.nbytes;
      end
      default: begin
        issue_en = 1'b0;
      end
    endcase
  end

  // Byte k of a beat starting at offset s sits in lane (s + k) mod 4, one row
  // further down for lanes below the starting lane.
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [1:0] k;
    logic       carry;
    logic       en;

    assign k     = 2'(b) - issue_s[1:0];
    assign carry = 2'(b) < issue_s[1:0];
    assign en    = issue_en && ({1'b0, k} < issue_nbytes);

    assign bank_we[b]    = clear_en || (en && issue_write);
    assign bank_addr[b]  = clear_en ? clr_row : RW'(issue_s[OW-1:2]) + RW'(carry);
    assign bank_wdata[b] = clear_en ? 8'h00 : issue_wdata[8*k +: 8];

    lsau_ram #(
      .WIDTH(8),
      .DEPTH(WORDS)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[b]),
      .addr (bank_addr[b]),
      .wdata(bank_wdata[b]),
      .rdata(bank_rdata[b])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      raw[8*i +: 8] = bank_rdata[2'(lane_q + 2'(i))];
    end
  end

  assign shaped = shape(raw, cur.nbytes, cur.rot, cur.swap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lsau_pkg::BK_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_en) begin
        clr_row <= clr_row + 1'b1;
      end
      done <= (state == lsau_pkg::BK_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= q_cmd;
      cur_off1 <= q_off1;
    end
    if (issue_en) begin
      lane_q <= issue_s[1:0];
    end
    if (state == lsau_pkg::BK_BEAT1) begin
      lo_word <= shaped;
    end
    if (state == lsau_pkg::BK_FIN) begin
      status <= cur.status;
      if (!cur.load || (cur.status != lsau_pkg::ST_OK)) begin
        read_data <= 64'd0;
      end else if (cur.nbeats == 2'd2) begin
        read_data <= {shaped, lo_word};
      end else begin
        read_data <= {32'd0, shaped};
      end
    end
  end

  `LSAU_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  `LSAU_ASSERT_IMPL(a_fault_zero, done && (status != lsau_pkg::ST_OK), read_data == 64'd0, "faulting result carries data")
  `LSAU_ASSERT_IMPL(a_clear_quiet, state == lsau_pkg::BK_CLEAR, !pop && !issue_en, "command taken during clearing")

endmodule

### rtl/load_store_align_unit.sv
// Load/store align unit: one command per transfer on start/busy, one result strobe per command.
// The back end takes one command at a time from the command queue: it pops it while idle, runs
// a memory beat on the byte-lane RAMs, and a second one when a doubleword access touches both
// words, and then forms the result, which is registered onto the result strobe; results never stall.
// Reset: window_base clears to 0 and a clearing pass zeroes the store, with busy high
// throughout; configuration transfers are taken at any time outside reset.
module load_store_align_unit #(
  parameter int MEM_BYTES = lsau_pkg::MEM_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation,
  input  logic [31:0] address,
  input  logic [63:0] write_data,
  output logic        done,
  output logic [63:0] read_data,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int OW = $clog2(MEM_BYTES);
  localparam int QW = $bits(lsau_pkg::cmd_t) + 2 * OW;

  lsau_pkg::front_ctl_t ctl;
  logic                 front_push;
  lsau_pkg::cmd_t       front_cmd;
  logic [OW-1:0]        front_off0;
  logic [OW-1:0]        front_off1;

  logic                 q_valid;
  logic [QW-1:0]        q_head;
  logic                 q_full;
  logic                 q_pop;
  lsau_pkg::cmd_t       q_cmd;
  logic [OW-1:0]        q_off0;
  logic [OW-1:0]        q_off1;
  logic                 clearing;

  assign ctl.queue_full = q_full;
  assign ctl.clearing   = clearing;

  lsau_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .address   (address),
    .write_data(write_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .push      (front_push),
    .cmd       (front_cmd),
    .off0      (front_off0),
    .off1      (front_off1)
  );

  lsau_cmd_queue #(
    .WIDTH(QW),
    .DEPTH(lsau_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_data({front_cmd, front_off0, front_off1}),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head),
    .full     (q_full)
  );

  assign {q_cmd, q_off0, q_off1} = q_head;

  lsau_back #(
    .MEM_BYTES(MEM_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_off0   (q_off0),
    .q_off1   (q_off1),
    .pop      (q_pop),
    .clearing (clearing),
    .done     (done),
    .read_data(read_data),
    .status   (status)
  );

endmodule
